// ===== hdl/wtalu_pkg.sv =====
package wtalu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned ShW = 6;
  localparam int unsigned WidthW = 7;

  typedef enum logic [3:0] {
    ActAdd  = 4'd0,
    ActSub  = 4'd1,
    ActMul  = 4'd2,
    ActSdiv = 4'd3,
    ActSrem = 4'd4,
    ActAnd  = 4'd5,
    ActOr   = 4'd6,
    ActXor  = 4'd7,
    ActShl  = 4'd8,
    ActAshr = 4'd9,
    ActLshr = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    KindInt   = 2'd0,
    KindBool  = 2'd1,
    KindOther = 2'd2
  } kind_e;

  // Data that travels from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic [3:0]        act;
    logic [1:0]        kind;
    logic [WidthW-1:0] wid;
    logic              neg_q;     // quotient sign
    logic              neg_r;     // remainder sign
    logic              zero_div;
    logic [DataW-1:0]  lhs;
    logic [DataW-1:0]  rhs;
    logic [DataW-1:0]  quo;       // quotient bits / dividend shift
    logic [DataW:0]    rem;       // partial remainder
    logic [DataW-1:0]  dvs;       // divisor magnitude
    logic [DataW-1:0]  raw;       // result of add, sub, logic and shift ops
  } cell_t;

endpackage

// ===== hdl/wtalu_cell.sv =====
// One restoring-division step per cell; everything else rides along.
module wtalu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  wtalu_pkg::cell_t   cell_i,
  output wtalu_pkg::cell_t   cell_o
);

  wtalu_pkg::cell_t cell_d, cell_q;
  logic [wtalu_pkg::DataW:0] trial;
  logic [wtalu_pkg::DataW:0] diff;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    cell_d = cell_i;
    trial = {cell_i.rem[wtalu_pkg::DataW-1:0], cell_i.quo[wtalu_pkg::DataW-1]};
    diff = trial - {1'b0, cell_i.dvs};
    if (!diff[wtalu_pkg::DataW]) begin
      cell_d.rem = diff;
      cell_d.quo = {cell_i.quo[wtalu_pkg::DataW-2:0], 1'b1};
    end else begin
      cell_d.rem = trial;
      cell_d.quo = {cell_i.quo[wtalu_pkg::DataW-2:0], 1'b0};
    end
  end

  // The whole beat moves on when the chain is enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== hdl/wtalu_front.sv =====
// Entry stage: operand prep and the add, subtract, logic and shift operations.
module wtalu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [3:0]                  action_i,
  input  logic [wtalu_pkg::DataW-1:0] lhs_i,
  input  logic [wtalu_pkg::DataW-1:0] rhs_i,
  input  logic [1:0]                  type_kind_i,
  input  logic [wtalu_pkg::WidthW-1:0] width_bits_i,
  output wtalu_pkg::cell_t            cell_o
);

  wtalu_pkg::cell_t cell_d, cell_q;
  logic [wtalu_pkg::ShW-1:0] sh;
  logic [wtalu_pkg::DataW-1:0] mag_a, mag_b;

  assign sh = rhs_i[wtalu_pkg::ShW-1:0];
  assign mag_a = lhs_i[wtalu_pkg::DataW-1] ? (~lhs_i + 1'b1) : lhs_i;
  assign mag_b = rhs_i[wtalu_pkg::DataW-1] ? (~rhs_i + 1'b1) : rhs_i;

  // Add, subtract, logic and shift results; multiply is finished later in the chain.
  always_comb begin
    cell_d = '0;
    cell_d.vld = valid_i;
    cell_d.act = action_i;
    cell_d.kind = type_kind_i;
    cell_d.wid = width_bits_i;
    cell_d.lhs = lhs_i;
    cell_d.rhs = rhs_i;
    cell_d.neg_q = lhs_i[wtalu_pkg::DataW-1] ^ rhs_i[wtalu_pkg::DataW-1];
    cell_d.neg_r = lhs_i[wtalu_pkg::DataW-1];
    cell_d.zero_div = (rhs_i == '0);
    cell_d.quo = mag_a;
    cell_d.dvs = mag_b;
    case (action_i)
      wtalu_pkg::ActAdd:  cell_d.raw = lhs_i + rhs_i;
      wtalu_pkg::ActSub:  cell_d.raw = lhs_i - rhs_i;
      wtalu_pkg::ActAnd:  cell_d.raw = lhs_i & rhs_i;
      wtalu_pkg::ActOr:   cell_d.raw = lhs_i | rhs_i;
      wtalu_pkg::ActXor:  cell_d.raw = lhs_i ^ rhs_i;
      wtalu_pkg::ActShl:  cell_d.raw = lhs_i << sh;
      wtalu_pkg::ActAshr: cell_d.raw = $unsigned($signed(lhs_i) >>> sh);
      wtalu_pkg::ActLshr: cell_d.raw = lhs_i >> sh;
      default:            cell_d.raw = '0;
    endcase
  end

  // The entry register loads a new beat whenever the chain is enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== hdl/wtalu_mul.sv =====
// 64x64 low-half multiply as three 32x32 partial products over two stages.
module wtalu_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [wtalu_pkg::DataW-1:0] a_i,
  input  logic [wtalu_pkg::DataW-1:0] b_i,
  output logic [wtalu_pkg::DataW-1:0] p_o
);

  localparam int unsigned HalfW = wtalu_pkg::DataW / 2;

  logic [wtalu_pkg::DataW-1:0] ll_q;
  logic [HalfW-1:0] lh_q, hl_q;
  logic [wtalu_pkg::DataW-1:0] p_q;

  // Stage one: partial products; the cross terms only need their low half,
  // and high times high drops out of the low half entirely.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[HalfW-1:0] * b_i[HalfW-1:0];
      lh_q <= a_i[HalfW-1:0] * b_i[wtalu_pkg::DataW-1:HalfW];
      hl_q <= a_i[wtalu_pkg::DataW-1:HalfW] * b_i[HalfW-1:0];
    end
  end

  // Stage two: combine.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ll_q + {lh_q + hl_q, {HalfW{1'b0}}};
    end
  end

  assign p_o = p_q;

endmodule

// ===== hdl/width_truncating_integer_alu_core.sv =====
// Channel | valid         | stall         | payload
// in      | in_valid_i    | in_stall_o    | action_i lhs_i rhs_i type_kind_i width_bits_i
// out     | out_valid_o   | out_stall_i   | value_o ok_o
//
// The path is one entry stage, 64 division cells (one quotient bit per cell),
// and one output stage; one beat is accepted every cycle unless the chain is stalled.
// The multiplier runs alongside the first two division cells.
// Reset clears all valid flags; no result is produced until a beat enters.
// While a result is waiting, a stall on the output freezes the whole chain,
// which then stalls the input as well.
module width_truncating_integer_alu_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3:0]                    action_i,
  input  logic signed [wtalu_pkg::DataW-1:0] lhs_i,
  input  logic signed [wtalu_pkg::DataW-1:0] rhs_i,
  input  logic [1:0]                    type_kind_i,
  input  logic [wtalu_pkg::WidthW-1:0]  width_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [wtalu_pkg::DataW-1:0] value_o,
  output logic                          ok_o
);

  localparam int unsigned Cells = wtalu_pkg::DataW;

  wtalu_pkg::cell_t chain [Cells+1];
  logic en;
  logic [wtalu_pkg::DataW-1:0] prod;
  logic [wtalu_pkg::DataW-1:0] prod_hold_q;

  logic out_vld_q, ok_q;
  logic [wtalu_pkg::DataW-1:0] val_q;
  logic ok_d;
  logic [wtalu_pkg::DataW-1:0] raw_d, val_d, mask;

  // The chain advances unless a finished result is held back.
  assign en = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  wtalu_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .action_i,
    .lhs_i(lhs_i), .rhs_i(rhs_i), .type_kind_i, .width_bits_i,
    .cell_o(chain[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    wtalu_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  wtalu_mul u_mul (
    .clk_i, .en_i(en), .a_i(chain[0].lhs), .b_i(chain[0].rhs), .p_o(prod)
  );

  // Carry the product down the chain in a shift line beside the cells.
  logic [wtalu_pkg::DataW-1:0] prod_line_q [Cells-2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_line_q[0] <= prod;
      for (int k = 1; k < Cells-2; k++) prod_line_q[k] <= prod_line_q[k-1];
    end
  end
  assign prod_hold_q = prod_line_q[Cells-3];

  // Select the raw result, handle division corner cases, then fit to type.
  // The most negative value divided by minus one comes out of the cells as
  // the most negative value already, with a zero remainder.
  always_comb begin
    wtalu_pkg::cell_t c;
    c = chain[Cells];
    ok_d = 1'b1;
    case (c.act)
      wtalu_pkg::ActMul: raw_d = prod_hold_q;
      wtalu_pkg::ActSdiv, wtalu_pkg::ActSrem: begin
        if (c.zero_div) begin
          ok_d = 1'b0;
          raw_d = '0;
        end else if (c.act == wtalu_pkg::ActSdiv) begin
          raw_d = c.neg_q ? (~c.quo + 1'b1) : c.quo;
        end else begin
          raw_d = c.neg_r ? (~c.rem[wtalu_pkg::DataW-1:0] + 1'b1)
                          : c.rem[wtalu_pkg::DataW-1:0];
        end
      end
      wtalu_pkg::ActAdd, wtalu_pkg::ActSub, wtalu_pkg::ActAnd, wtalu_pkg::ActOr,
      wtalu_pkg::ActXor, wtalu_pkg::ActShl, wtalu_pkg::ActAshr,
      wtalu_pkg::ActLshr: raw_d = c.raw;
      default: begin
        ok_d = 1'b0;
        raw_d = '0;
      end
    endcase
    mask = {wtalu_pkg::DataW{1'b1}} >> (wtalu_pkg::WidthW'(Cells) - c.wid);
    val_d = raw_d;
    if (!ok_d) begin
      val_d = '0;
    end else if (c.kind == wtalu_pkg::KindBool) begin
      val_d = {{(wtalu_pkg::DataW-1){1'b0}}, raw_d[0]};
    end else if (c.kind == wtalu_pkg::KindInt && c.wid != '0
                 && c.wid < wtalu_pkg::WidthW'(Cells)) begin
      val_d = raw_d & mask;
      if (raw_d[c.wid[wtalu_pkg::ShW-1:0] - 1'b1]) val_d = val_d | ~mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[Cells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      ok_q <= ok_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o = val_q;
  assign ok_o = ok_q;

endmodule

// ===== hdl/wtalu_checker.sv =====
// Port-level checks for the ALU core.
module wtalu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [wtalu_pkg::DataW-1:0] value_o,
  input logic                        ok_o
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(ok_o))
    else $error("stalled result changed");

  // The input is stalled only while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // A failed fold always reports zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> value_o == '0)
    else $error("failed fold with nonzero value");

  // No stall is ever raised when nothing is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall with empty output");

endmodule

bind width_truncating_integer_alu_core wtalu_checker u_wtalu_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .value_o, .ok_o
);
